[src/mcg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_pkg
// Widths, constants, the month offset table and the controller/datapath
// command and status types of the month calendar grid.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ROW_W   = 3;
  localparam int WDAY_W  = 3;

  // Shifted year (year + 400, less one for January and February).
  localparam int SHY_W   = YEAR_W + 1;
  // Weekday sum before the reduction modulo seven.
  localparam int SUM_W   = 15;
  // Quotients by 100 and by 7.
  localparam int Q100_W  = 8;
  localparam int Q7_W    = 12;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

  localparam logic [8:0] YEAR_SHIFT = 9'd400;
  localparam logic [6:0] CENTURY    = 7'd100;
  localparam logic [2:0] DAYS_WEEK  = 3'd7;

  // x / 100 = (x * K100) >> S100, exact for x below 2^15.
  localparam int              S100 = 21;
  localparam logic [14:0]     K100 = 15'd20972;
  // x / 7 = (x * K7) >> S7, exact for x below 2^15.
  localparam int              S7   = 18;
  localparam logic [15:0]     K7   = 16'd37450;

  typedef struct packed {
    logic load;
    logic calc_div;
    logic calc_sum;
    logic calc_mod;
    logic first_day;
    logic advance;
  } mcg_cmd_t;

  typedef struct packed {
    logic month_ok;
    logic last_day;
  } mcg_sts_t;

  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    unique case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

[src/mcg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_in_if
// Request channel: one item carries a year, a month and a selected day.
// ----------------------------------------------------------------------------
interface mcg_in_if;
  import mcg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     selected_day;

  modport source (output valid, output year, output month, output selected_day,
                  input ready);
  modport sink   (input valid, input year, input month, input selected_day,
                  output ready);
endinterface
`default_nettype wire

[src/mcg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_out_if
// Result channel: one item describes one day cell of the month grid.
// ----------------------------------------------------------------------------
interface mcg_out_if;
  import mcg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     day_number;
  logic [ROW_W-1:0]     week_row;
  logic [WDAY_W-1:0]    weekday;
  logic                 is_selected;
  logic                 last;

  modport source (output valid, output day_number, output week_row,
                  output weekday, output is_selected, output last, input ready);
  modport sink   (input valid, input day_number, input week_row,
                  input weekday, input is_selected, input last, output ready);
endinterface
`default_nettype wire

[src/mcg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_ctrl
// Sequencer: takes a request, steps the datapath through the weekday setup
// and then hands out one day cell per accepted result.
// ----------------------------------------------------------------------------
module mcg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mcg_pkg::mcg_sts_t  sts,
  output mcg_pkg::mcg_cmd_t       cmd
);
  import mcg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SUM,
    S_MOD,
    S_FIRST,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_fire;

  assign in_fire  = in_valid && in_ready_r;
  assign out_fire = out_valid_r && out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load     = 1'b1;
          state_nxt    = S_DIV;
          in_ready_nxt = 1'b0;
        end
      end
      S_DIV: begin
        cmd.calc_div = 1'b1;
        // A month outside January to December yields no cells at all.
        if (sts.month_ok) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = S_MOD;
      end
      S_MOD: begin
        cmd.calc_mod = 1'b1;
        state_nxt    = S_FIRST;
      end
      S_FIRST: begin
        cmd.first_day = 1'b1;
        state_nxt     = S_EMIT;
        out_valid_nxt = 1'b1;
      end
      S_EMIT: begin
        if (out_fire) begin
          if (sts.last_day) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b0;
            in_ready_nxt  = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_ready_nxt  = 1'b1;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[src/mcg_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_dp
// Datapath: month length with the Gregorian leap rule, weekday of the first
// day by the month offset table, then day, weekday and row counters.
// ----------------------------------------------------------------------------
module mcg_dp (
  input  wire logic                          clk,
  input  wire mcg_pkg::mcg_cmd_t             cmd,
  output mcg_pkg::mcg_sts_t                  sts,
  input  wire logic [mcg_pkg::YEAR_W-1:0]    in_year,
  input  wire logic [mcg_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [mcg_pkg::DAY_W-1:0]     in_selected_day,
  output logic [mcg_pkg::DAY_W-1:0]          out_day_number,
  output logic [mcg_pkg::ROW_W-1:0]          out_week_row,
  output logic [mcg_pkg::WDAY_W-1:0]         out_weekday,
  output logic                               out_is_selected,
  output logic                               out_last
);
  import mcg_pkg::*;

  localparam int PY_W  = YEAR_W + 15;
  localparam int PD_W  = SHY_W + 15;
  localparam int P7_W  = SUM_W + 16;

  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   sel_r;
  logic [Q100_W-1:0]  qy_r;
  logic [Q100_W-1:0]  qd_r;
  logic [SUM_W-1:0]   sum_r;
  logic [DAY_W-1:0]   len_r;
  logic [Q7_W-1:0]    q7_r;
  logic [DAY_W-1:0]   day_r;
  logic [WDAY_W-1:0]  wd_r;
  logic [ROW_W-1:0]   row_r;

  logic [SHY_W-1:0]   shy;
  logic [PY_W-1:0]    prod_y;
  logic [PD_W-1:0]    prod_d;
  logic [P7_W-1:0]    prod_7;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SHY_W-1:0]   cent_year;
  logic               leap;
  logic [DAY_W-1:0]   len_nxt;
  logic [SUM_W-1:0]   rem7;
  logic [WDAY_W-1:0]  wd_first;
  logic [WDAY_W-1:0]  wd_step;

  function automatic logic [SHY_W-1:0] in_year_r_ext(input logic [YEAR_W-1:0]  y,
                                                     input logic [MONTH_W-1:0] m);
    logic [SHY_W-1:0] base;
    base = SHY_W'(y) + SHY_W'(YEAR_SHIFT);
    if (m < MONTH_MAR) begin
      base = base - SHY_W'(1);
    end
    return base;
  endfunction

  // The 400 added years are a whole number of weeks and keep year 0 positive.
  assign shy = SHY_W'(in_year_r_ext(year_r, month_r)) ;

  assign prod_y = PY_W'(year_r) * PY_W'(K100);
  assign prod_d = PD_W'(shy) * PD_W'(K100);
  assign prod_7 = P7_W'(sum_r) * P7_W'(K7);

  assign sum_nxt = SUM_W'(shy) + SUM_W'(shy >> 2) - SUM_W'(qd_r) + SUM_W'(qd_r >> 2)
                 + SUM_W'(month_offset(month_r)) + SUM_W'(1);

  // Divisible by 400 is divisible by 100 with a quotient divisible by 4.
  assign cent_year = SHY_W'(qy_r) * SHY_W'(CENTURY);
  assign leap = (year_r[1:0] == 2'b00) &&
                ((cent_year != SHY_W'(year_r)) || (qy_r[1:0] == 2'b00));

  always_comb begin
    if (month_r == MONTH_APR || month_r == MONTH_JUN ||
        month_r == MONTH_SEP || month_r == MONTH_NOV) begin
      len_nxt = LEN_30;
    end else if (month_r == MONTH_FEB) begin
      len_nxt = leap ? LEN_29 : LEN_28;
    end else begin
      len_nxt = LEN_31;
    end
  end

  assign rem7     = sum_r - SUM_W'(SUM_W'(q7_r) * SUM_W'(DAYS_WEEK));
  assign wd_first = rem7[WDAY_W-1:0];
  assign wd_step  = (wd_r == WDAY_W'(DAYS_WEEK - 3'd1)) ? '0 : wd_r + WDAY_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_year;
      month_r <= in_month;
      sel_r   <= in_selected_day;
    end
    if (cmd.calc_div) begin
      qy_r <= prod_y[S100 +: Q100_W];
      qd_r <= prod_d[S100 +: Q100_W];
    end
    if (cmd.calc_sum) begin
      sum_r <= sum_nxt;
      len_r <= len_nxt;
    end
    if (cmd.calc_mod) begin
      q7_r <= prod_7[S7 +: Q7_W];
    end
    // The row goes up before each Sunday, the first day included.
    if (cmd.first_day) begin
      day_r <= DAY_W'(1);
      wd_r  <= wd_first;
      row_r <= (wd_first == '0) ? ROW_W'(1) : '0;
    end else if (cmd.advance) begin
      day_r <= day_r + DAY_W'(1);
      wd_r  <= wd_step;
      row_r <= (wd_step == '0) ? row_r + ROW_W'(1) : row_r;
    end
  end

  assign sts.month_ok = (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC);
  assign sts.last_day = (day_r == len_r);

  assign out_day_number  = day_r;
  assign out_week_row    = row_r;
  assign out_weekday     = wd_r;
  assign out_is_selected = (day_r == sel_r);
  assign out_last        = (day_r == len_r);

endmodule
`default_nettype wire

[src/month_calendar_grid.sv]
`default_nettype none
// The first day cell is offered once a taken request has passed the four setup
// steps. Throughput: one cell per cycle while the sink is ready; a request
// occupies the block through the idle state that takes it, the four setup steps
// and one emit step per day; no new request is taken before its last cell goes.
// A month outside 1 to 12 goes from the divide step back to idle with no cells.
// Reset is synchronous and active low; it leaves the block idle and ready.
// ----------------------------------------------------------------------------
// month_calendar_grid
// Lays out one Gregorian month as a sequence of day cells with weekday
// column, week row, selected flag and a marker on the final day.
// ----------------------------------------------------------------------------
module month_calendar_grid (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcg_in_if.sink     in_ch,
  mcg_out_if.source  out_ch
);
  import mcg_pkg::*;

  mcg_cmd_t cmd;
  mcg_sts_t sts;

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcg_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_year         (in_ch.year),
    .in_month        (in_ch.month),
    .in_selected_day (in_ch.selected_day),
    .out_day_number  (out_ch.day_number),
    .out_week_row    (out_ch.week_row),
    .out_weekday     (out_ch.weekday),
    .out_is_selected (out_ch.is_selected),
    .out_last        (out_ch.last)
  );

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for month_calendar_grid. A queue of directed and random
// requests feeds a driver that pauses at random between items. Each accepted
// request is laid out by an independent calendar model into the day cells it
// should produce. A monitor with random back-pressure checks every cell
// against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module tb;
  import mcg_pkg::*;

  localparam int RANDOM_MONTHS = 222;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   sel_day;
    bit                 wait_drain;
  } month_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [ROW_W-1:0]  row;
    logic [WDAY_W-1:0] wday;
    logic              sel;
    logic              last;
  } day_cell_t;

  // Sakamoto's month offsets, January first.
  localparam int unsigned MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic clk = 1'b0;
  logic rst_n;

  mcg_in_if  in_ch ();
  mcg_out_if out_ch ();

  month_calendar_grid DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  month_req_t pending_reqs [$];
  day_cell_t  expected_cells [$];

  bit req_taken;
  bit cell_taken;
  bit in_calm;
  bit out_calm;
  int gap_left;
  int stall_left;
  int quiet_cycles;
  int errors;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expands one request into the day cells the grid should emit.
  function automatic void lay_out_month(month_req_t r);
    int unsigned len;
    int unsigned y;
    int unsigned base;
    int unsigned wd;
    logic [ROW_W-1:0] row;
    day_cell_t c;
    if (r.month < MONTH_JAN || r.month > MONTH_DEC) return;
    case (r.month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      MONTH_FEB: begin
        if ((r.year % 4 == 0 && r.year % 100 != 0) || r.year % 400 == 0) len = LEN_29;
        else len = LEN_28;
      end
      default: len = LEN_31;
    endcase
    // The added 400 years are a whole number of weeks and keep year 0 positive.
    y = int'(r.year) + 400 - ((r.month < MONTH_MAR) ? 1 : 0);
    base = y + y / 4 - y / 100 + y / 400 + MONTH_SHIFT[r.month - 1];
    row = '0;
    for (int d = 1; d <= len; d++) begin
      wd = (base + d) % 7;
      if (wd == 0) row++;
      c.day  = DAY_W'(d);
      c.row  = row;
      c.wday = WDAY_W'(wd);
      c.sel  = (d == r.sel_day);
      c.last = (d == len);
      expected_cells = {expected_cells, c};
    end
  endfunction

  function automatic int draw_pause(bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  task automatic add_request(int y, int m, int s, bit drain);
    month_req_t r;
    r.year       = YEAR_W'(y);
    r.month      = MONTH_W'(m);
    r.sel_day    = DAY_W'(s);
    r.wait_drain = drain;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  // Request driver: holds an item until it is taken, then waits a drawn gap.
  always @(negedge clk) begin
    month_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      if (req_taken) begin
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        gap_left = draw_pause(in_calm);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].wait_drain && expected_cells.size() != 0)) begin
        nxt = pending_reqs.pop_front();
        in_ch.year         <= nxt.year;
        in_ch.month        <= nxt.month;
        in_ch.selected_day <= nxt.sel_day;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Cell sink: after each item taken, withholds ready for a drawn stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (cell_taken || !out_ch.ready) begin
      if (cell_taken) begin
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        stall_left = draw_pause(out_calm);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Handshake monitor, cell checker and watchdog.
  always @(posedge clk) begin
    month_req_t taken;
    day_cell_t  want;
    req_taken  = rst_n && in_ch.valid && in_ch.ready;
    cell_taken = rst_n && out_ch.valid && out_ch.ready;
    if (req_taken) begin
      taken.year       = in_ch.year;
      taken.month      = in_ch.month;
      taken.sel_day    = in_ch.selected_day;
      taken.wait_drain = 1'b0;
      lay_out_month(taken);
    end
    if (cell_taken) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual day %0d row %0d weekday %0d",
                 $time, out_ch.day_number, out_ch.week_row, out_ch.weekday);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_ch.day_number !== want.day)
          note_mismatch("day_number", want.day, out_ch.day_number);
        if (out_ch.week_row !== want.row)
          note_mismatch("week_row", want.row, out_ch.week_row);
        if (out_ch.weekday !== want.wday)
          note_mismatch("weekday", want.wday, out_ch.weekday);
        if (out_ch.is_selected !== want.sel)
          note_mismatch("is_selected", want.sel, out_ch.is_selected);
        if (out_ch.last !== want.last)
          note_mismatch("last", want.last, out_ch.last);
      end
    end
    if (!rst_n || req_taken || cell_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n_months;
    int y;
    int m;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.year         = '0;
    in_ch.month        = '0;
    in_ch.selected_day = '0;
    out_ch.ready       = 1'b0;

    // Directed part: field extremes, leap rules, short months, out-of-range cases.
    add_request(1,     1,  1,  0);
    add_request(9999,  12, 31, 0);
    add_request(0,     1,  0,  0);
    add_request(0,     2,  29, 0);
    add_request(16383, 2,  15, 0);
    add_request(16383, 15, 31, 0);
    add_request(2000,  2,  29, 0);
    add_request(1900,  2,  29, 0);
    add_request(2024,  2,  30, 0);
    add_request(2023,  2,  28, 0);
    add_request(1,     0,  5,  0);
    add_request(2021,  13, 1,  0);
    add_request(2021,  14, 3,  0);
    add_request(2021,  4,  31, 1);
    add_request(2021,  6,  30, 0);
    add_request(2021,  9,  1,  0);
    add_request(2021,  11, 17, 0);
    add_request(2021,  5,  2,  0);
    add_request(2015,  2,  1,  0);
    add_request(10000, 2,  29, 1);
    add_request(8192,  7,  16, 0);
    add_request(5461,  8,  10, 0);
    add_request(10922, 10, 21, 0);
    add_request(1752,  9,  14, 0);

    // Random part: mostly ordinary years, some centuries and the full field.
    n_months = 0;
    while (n_months < RANDOM_MONTHS) begin
      case ($urandom_range(0, 9))
        0:       y = $urandom_range(0, 16383);
        1:       y = $urandom_range(0, 99) * 100;
        default: y = $urandom_range(1, 9999);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        m = $urandom_range(0, 3);
        if (m != 0) m += 12;
      end else begin
        m = $urandom_range(MONTH_JAN, MONTH_DEC);
        n_months++;
      end
      add_request(y, m, $urandom_range(0, 31), $urandom_range(0, 24) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sampled at the rising edge, where the driven request is settled.
    do @(posedge clk); while (pending_reqs.size() != 0 || in_ch.valid);
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[month_calendar_grid.f]
src/mcg_pkg.sv
src/mcg_in_if.sv
src/mcg_out_if.sv
src/mcg_ctrl.sv
src/mcg_dp.sv
src/month_calendar_grid.sv
bench/tb.sv
